/* hdl/htnm_pkg.sv */
`timescale 1ns / 1ps

package htnm_pkg;

   // Default geometry limits
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 4096;

   // Field and register widths
   localparam int HEIGHT_W       = 8;
   localparam int SCALE_W        = 16;
   localparam int WIDTH_CFG_W    = 11;
   localparam int HEIGHT_CFG_W   = 13;
   localparam int CFG_DATA_W     = 16;
   localparam int CFG_INDEX_W    = 2;
   localparam int CHAN_W         = 8;

   // Register reset values
   localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET   = 11'd256;
   localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET  = 13'd256;
   localparam logic [SCALE_W-1:0]      SCALE_RESET   = 16'd256;
   localparam logic [SCALE_W-1:0]      SPACING_RESET = 16'd6554;

   typedef enum logic [CFG_INDEX_W-1:0] {
      REG_IMAGE_WIDTH   = 2'd0,
      REG_IMAGE_HEIGHT  = 2'd1,
      REG_HEIGHT_SCALE  = 2'd2,
      REG_PIXEL_SPACING = 2'd3
   } csr_index_type;

   // Shared divider: numerator, divisor and partial remainder widths
   localparam int DIV_NUM_W = 41;
   localparam int DIV_DEN_W = 25;
   localparam int DIV_REM_W = 26;
   localparam int DIV_CNT_W = 6;

   // Slope magnitude, sum of squares and square root step count
   localparam int SLOPE_W  = 25;
   localparam int SUMSQ_W  = 50;
   localparam int SQ_STEPS = 25;
   localparam int SQ_CNT_W = 5;

   // Division by 255 of the slope as a multiply by ceil(2^32 / 255)
   localparam int SLOPE_ROUND       = 127;
   localparam int SLOPE_RECIP       = 16843010;
   localparam int SLOPE_RECIP_SHIFT = 32;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] numerator;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_OLD,
      ST_RD_RIGHT,
      ST_SETUP,
      ST_MUL_H,
      ST_DIV_H,
      ST_MUL_V,
      ST_DIV_V,
      ST_SQ_H,
      ST_SQ_V,
      ST_SQ_S,
      ST_SQRT,
      ST_LD_R,
      ST_DIV_R,
      ST_LD_G,
      ST_DIV_G,
      ST_LD_B,
      ST_DIV_B,
      ST_EMIT,
      ST_WRAP
   } state_type;

endpackage

/* hdl/htnm_if.sv */
`timescale 1ns / 1ps

interface htnm_req_if;
   logic                          valid;
   logic                          ready;
   logic [htnm_pkg::HEIGHT_W-1:0] height_sample;

   modport source (output valid, output height_sample, input ready);
   modport sink   (input valid, input height_sample, output ready);
endinterface

interface htnm_rsp_if #(
   parameter int COL_W = $clog2(htnm_pkg::MAX_WIDTH_DEF),
   parameter int ROW_W = $clog2(htnm_pkg::MAX_HEIGHT_DEF)
);
   logic                        valid;
   logic                        ready;
   logic [COL_W-1:0]            pixel_column;
   logic [ROW_W-1:0]            pixel_row;
   logic [htnm_pkg::CHAN_W-1:0] normal_red;
   logic [htnm_pkg::CHAN_W-1:0] normal_green;
   logic [htnm_pkg::CHAN_W-1:0] normal_blue;
   logic                        last_of_run;

   modport source (output valid, output pixel_column, output pixel_row, output normal_red,
                   output normal_green, output normal_blue, output last_of_run, input ready);
   modport sink   (input valid, input pixel_column, input pixel_row, input normal_red,
                   input normal_green, input normal_blue, input last_of_run, output ready);
endinterface

/* hdl/htnm_divider.sv */
`timescale 1ns / 1ps

module htnm_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  htnm_pkg::div_req_type div_req,
   output htnm_pkg::div_rsp_type div_rsp
);

   logic [htnm_pkg::DIV_NUM_W-1:0] num_ff, num_in;
   logic [htnm_pkg::DIV_DEN_W-1:0] den_ff, den_in;
   logic [htnm_pkg::DIV_REM_W-1:0] rem_ff, rem_in;
   logic [htnm_pkg::DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [htnm_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [htnm_pkg::DIV_REM_W:0]   trial;
   logic [htnm_pkg::DIV_REM_W:0]   diff;
   logic                           ge;

   // One quotient bit per cycle: shift in the next numerator bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, num_ff[htnm_pkg::DIV_NUM_W-1]};
      diff    = trial - {2'b00, den_ff};
      ge      = ~diff[htnm_pkg::DIV_REM_W];
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         num_in  = div_req.numerator;
         den_in  = div_req.divisor;
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[htnm_pkg::DIV_NUM_W-2:0], 1'b0};
         rem_in = ge ? diff[htnm_pkg::DIV_REM_W-1:0] : trial[htnm_pkg::DIV_REM_W-1:0];
         quo_in = {quo_ff[htnm_pkg::DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == htnm_pkg::DIV_CNT_W'(htnm_pkg::DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* hdl/height_to_normal_map.sv */
`timescale 1ns / 1ps
// Normals of a transaction are computed and emitted one at a time; emission waits while the
// result register is stalled. Throughput: one transaction at a time, with zero to three
// normals each; set by the shared 41-step radix-2 divider (three divisions per normal) and
// the 25-step square root. Reset (synchronous, active high): registers to defaults, counters
// and neighbors to zero; the line buffer is not cleared, row 0 writes it before any read.

module height_to_normal_map #(
   parameter int MAX_WIDTH  = htnm_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = htnm_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   htnm_req_if.sink                         req_chan,
   htnm_rsp_if.source                       rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [htnm_pkg::CFG_INDEX_W-1:0] csr_index,
   input  logic [htnm_pkg::CFG_DATA_W-1:0]  csr_write_data
);

   localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HW    = htnm_pkg::HEIGHT_W;
   localparam int SW    = htnm_pkg::SLOPE_W;
   localparam int QW    = htnm_pkg::SUMSQ_W;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [HW-1:0]    centre;
      logic [HW-1:0]    hnb;
      logic [HW-1:0]    vnb;
   } job_type;

   function automatic logic [htnm_pkg::CHAN_W-1:0] chan_map(input logic neg,
                                                           input logic [16:0] q);
      logic [17:0] t;
      logic [25:0] p;
      t = neg ? (18'd65536 - {1'b0, q}) : (18'd65536 + {1'b0, q});
      p = {t, 8'd0} - {8'd0, t};
      return p[24:17];
   endfunction

   htnm_pkg::state_type state_ff, state_in;

   logic [htnm_pkg::WIDTH_CFG_W-1:0]  width_cfg_ff, width_cfg_in;
   logic [htnm_pkg::HEIGHT_CFG_W-1:0] height_cfg_ff, height_cfg_in;
   logic [htnm_pkg::SCALE_W-1:0]      scale_ff, scale_in;
   logic [htnm_pkg::SCALE_W-1:0]      spacing_ff, spacing_in;

   logic [COL_W-1:0] col_cnt_ff, col_cnt_in;
   logic [ROW_W-1:0] row_cnt_ff, row_cnt_in;
   logic [HW-1:0]    left_ff, left_in;
   logic [HW-1:0]    upl_ff, upl_in;

   logic [HW-1:0]    cur_ff, cur_in;
   logic [HW-1:0]    old_ff, old_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] wlast_ff, wlast_in;
   logic [ROW_W-1:0] hlast_ff, hlast_in;

   job_type     job_ff [0:2];
   job_type     job_in [0:2];
   job_type     build_job [0:2];
   logic [1:0]  build_n;
   logic [1:0]  njob_ff, njob_in;
   logic [1:0]  jidx_ff, jidx_in;
   job_type     job_cur;

   logic          hneg_ff, hneg_in;
   logic          vneg_ff, vneg_in;
   logic [SW-1:0] dh_ff, dh_in;
   logic [SW-1:0] dv_ff, dv_in;
   logic [QW-1:0] acc_ff, acc_in;
   logic [QW-1:0] sq_v_ff, sq_v_in;
   logic [QW-1:0] sq_res_ff, sq_res_in;
   logic [QW-1:0] sq_bit_ff, sq_bit_in;
   logic [QW-1:0] sq_sum;
   logic [htnm_pkg::SQ_CNT_W-1:0] sq_cnt_ff, sq_cnt_in;
   logic [htnm_pkg::CHAN_W-1:0]   red_ff, red_in;
   logic [htnm_pkg::CHAN_W-1:0]   green_ff, green_in;
   logic [htnm_pkg::CHAN_W-1:0]   blue_ff, blue_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]            out_col_ff, out_col_in;
   logic [ROW_W-1:0]            out_row_ff, out_row_in;
   logic [htnm_pkg::CHAN_W-1:0] out_r_ff, out_r_in;
   logic [htnm_pkg::CHAN_W-1:0] out_g_ff, out_g_in;
   logic [htnm_pkg::CHAN_W-1:0] out_b_ff, out_b_in;
   logic                        out_last_ff, out_last_in;

   logic [HW-1:0]    line_mem [MAX_WIDTH];
   logic [HW-1:0]    mem_q;
   logic [COL_W-1:0] rd_addr;
   logic             mem_we;

   htnm_pkg::div_req_type div_req;
   htnm_pkg::div_rsp_type div_rsp;

   logic                         req_ready;
   logic                         slot_free;
   logic                         emit_load;
   logic                         last_job;
   logic [SW-1:0]                mul_a;
   logic [SW-1:0]                mul_b;
   logic [QW-1:0]                mul_prod;
   logic [HW-1:0]                hdiff;
   logic [HW-1:0]                vdiff;
   logic [htnm_pkg::SCALE_W-1:0] s_eff;
   logic [31:0]                  wfull;
   logic [31:0]                  hfull;
   logic [HW-1:0]                right_h;

   htnm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign job_cur   = job_ff[jidx_ff];
   assign slot_free = ~rsp_valid_ff | rsp_chan.ready;
   assign last_job  = (jidx_ff == (njob_ff - 2'd1));
   assign s_eff     = (spacing_ff == '0) ? 16'd1 : spacing_ff;
   assign hdiff     = (job_cur.hnb >= job_cur.centre) ? (job_cur.hnb - job_cur.centre)
                                                      : (job_cur.centre - job_cur.hnb);
   assign vdiff     = (job_cur.vnb >= job_cur.centre) ? (job_cur.vnb - job_cur.centre)
                                                      : (job_cur.centre - job_cur.vnb);

   // Line buffer: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[col_ff] <= cur_ff;
      end
      mem_q <= line_mem[rd_addr];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         htnm_pkg::ST_IDLE:     if (req_chan.valid) state_in = htnm_pkg::ST_RD_OLD;
         htnm_pkg::ST_RD_OLD:   state_in = htnm_pkg::ST_RD_RIGHT;
         htnm_pkg::ST_RD_RIGHT: state_in = htnm_pkg::ST_SETUP;
         htnm_pkg::ST_SETUP: begin
            state_in = (build_n == 2'd0) ? htnm_pkg::ST_WRAP : htnm_pkg::ST_MUL_H;
         end
         htnm_pkg::ST_MUL_H:    state_in = htnm_pkg::ST_DIV_H;
         htnm_pkg::ST_DIV_H:    state_in = htnm_pkg::ST_MUL_V;
         htnm_pkg::ST_MUL_V:    state_in = htnm_pkg::ST_DIV_V;
         htnm_pkg::ST_DIV_V:    state_in = htnm_pkg::ST_SQ_H;
         htnm_pkg::ST_SQ_H:     state_in = htnm_pkg::ST_SQ_V;
         htnm_pkg::ST_SQ_V:     state_in = htnm_pkg::ST_SQ_S;
         htnm_pkg::ST_SQ_S:     state_in = htnm_pkg::ST_SQRT;
         htnm_pkg::ST_SQRT: begin
            if (sq_cnt_ff == htnm_pkg::SQ_CNT_W'(htnm_pkg::SQ_STEPS - 1)) begin
               state_in = htnm_pkg::ST_LD_R;
            end
         end
         htnm_pkg::ST_LD_R:     state_in = htnm_pkg::ST_DIV_R;
         htnm_pkg::ST_DIV_R:    if (div_rsp.done) state_in = htnm_pkg::ST_LD_G;
         htnm_pkg::ST_LD_G:     state_in = htnm_pkg::ST_DIV_G;
         htnm_pkg::ST_DIV_G:    if (div_rsp.done) state_in = htnm_pkg::ST_LD_B;
         htnm_pkg::ST_LD_B:     state_in = htnm_pkg::ST_DIV_B;
         htnm_pkg::ST_DIV_B:    if (div_rsp.done) state_in = htnm_pkg::ST_EMIT;
         htnm_pkg::ST_EMIT: begin
            if (slot_free) begin
               state_in = last_job ? htnm_pkg::ST_WRAP : htnm_pkg::ST_MUL_H;
            end
         end
         htnm_pkg::ST_WRAP:     state_in = htnm_pkg::ST_IDLE;
         default:               state_in = htnm_pkg::ST_IDLE;
      endcase
   end

   // Control outputs: handshake, memory port, multiplier operands, divider requests
   // Slope: round(x * 256 / 255) with x = |d| * scale equals x + floor((x + 127) / 255);
   // the division by 255 is a multiply by the reciprocal on the shared multiplier
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      emit_load = 1'b0;
      rd_addr   = col_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_req   = '0;
      case (state_ff)
         htnm_pkg::ST_IDLE:     req_ready = 1'b1;
         htnm_pkg::ST_RD_RIGHT: rd_addr = col_ff + 1'b1;
         htnm_pkg::ST_MUL_H: begin
            mul_a = SW'(hdiff);
            mul_b = SW'(scale_ff);
         end
         htnm_pkg::ST_DIV_H: begin
            mul_a = dh_ff + SW'(htnm_pkg::SLOPE_ROUND);
            mul_b = SW'(htnm_pkg::SLOPE_RECIP);
         end
         htnm_pkg::ST_MUL_V: begin
            mul_a = SW'(vdiff);
            mul_b = SW'(scale_ff);
         end
         htnm_pkg::ST_DIV_V: begin
            mul_a = dv_ff + SW'(htnm_pkg::SLOPE_ROUND);
            mul_b = SW'(htnm_pkg::SLOPE_RECIP);
         end
         htnm_pkg::ST_SQ_H: begin
            mul_a = dh_ff;
            mul_b = dh_ff;
         end
         htnm_pkg::ST_SQ_V: begin
            mul_a = dv_ff;
            mul_b = dv_ff;
         end
         htnm_pkg::ST_SQ_S: begin
            mul_a = SW'(s_eff);
            mul_b = SW'(s_eff);
         end
         htnm_pkg::ST_EMIT:     emit_load = slot_free;
         htnm_pkg::ST_WRAP:     mem_we = 1'b1;
         default: begin
         end
      endcase
      mul_prod = QW'(mul_a) * QW'(mul_b);
      // Normalize each component by the vector length
      case (state_ff)
         htnm_pkg::ST_LD_R: begin
            div_req.start     = 1'b1;
            div_req.numerator = {dh_ff, 16'd0};
            div_req.divisor   = sq_res_ff[htnm_pkg::DIV_DEN_W-1:0];
         end
         htnm_pkg::ST_LD_G: begin
            div_req.start     = 1'b1;
            div_req.numerator = {dv_ff, 16'd0};
            div_req.divisor   = sq_res_ff[htnm_pkg::DIV_DEN_W-1:0];
         end
         htnm_pkg::ST_LD_B: begin
            div_req.start     = 1'b1;
            div_req.numerator = {9'd0, s_eff, 16'd0};
            div_req.divisor   = sq_res_ff[htnm_pkg::DIV_DEN_W-1:0];
         end
         default: begin
         end
      endcase
   end

   // Build the list of normals this transaction releases
   always_comb begin
      right_h   = (col_ff != wlast_ff) ? mem_q : upl_ff;
      build_job = job_ff;
      build_n   = 2'd0;
      if (row_ff != '0) begin
         build_job[0] = '{col_ff, row_ff - 1'b1, old_ff, right_h, cur_ff};
         build_n      = 2'd1;
         if (row_ff == hlast_ff) begin
            if (col_ff != '0) begin
               build_job[1] = '{col_ff - 1'b1, row_ff, left_ff, cur_ff, upl_ff};
               build_n      = 2'd2;
            end
            if (col_ff == wlast_ff) begin
               build_job[build_n] = '{col_ff, row_ff, cur_ff, left_ff, old_ff};
               build_n            = build_n + 2'd1;
            end
         end
      end
   end

   // Datapath next values
   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      scale_in      = scale_ff;
      spacing_in    = spacing_ff;
      col_cnt_in    = col_cnt_ff;
      row_cnt_in    = row_cnt_ff;
      left_in       = left_ff;
      upl_in        = upl_ff;
      cur_in        = cur_ff;
      old_in        = old_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      wlast_in      = wlast_ff;
      hlast_in      = hlast_ff;
      job_in        = job_ff;
      njob_in       = njob_ff;
      jidx_in       = jidx_ff;
      hneg_in       = hneg_ff;
      vneg_in       = vneg_ff;
      dh_in         = dh_ff;
      dv_in         = dv_ff;
      acc_in        = acc_ff;
      sq_v_in       = sq_v_ff;
      sq_res_in     = sq_res_ff;
      sq_bit_in     = sq_bit_ff;
      sq_cnt_in     = sq_cnt_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      out_col_in    = out_col_ff;
      out_row_in    = out_row_ff;
      out_r_in      = out_r_ff;
      out_g_in      = out_g_ff;
      out_b_in      = out_b_ff;
      out_last_in   = out_last_ff;
      sq_sum        = sq_res_ff + sq_bit_ff;

      // Clamp geometry to the supported range
      wfull = 32'(width_cfg_ff);
      if (wfull < 32'd2) wfull = 32'd2;
      if (wfull > 32'(MAX_WIDTH)) wfull = 32'(MAX_WIDTH);
      hfull = 32'(height_cfg_ff);
      if (hfull < 32'd2) hfull = 32'd2;
      if (hfull > 32'(MAX_HEIGHT)) hfull = 32'(MAX_HEIGHT);

      // Register writes
      if (csr_write_enable) begin
         case (htnm_pkg::csr_index_type'(csr_index))
            htnm_pkg::REG_IMAGE_WIDTH:
               width_cfg_in = csr_write_data[htnm_pkg::WIDTH_CFG_W-1:0];
            htnm_pkg::REG_IMAGE_HEIGHT:
               height_cfg_in = csr_write_data[htnm_pkg::HEIGHT_CFG_W-1:0];
            htnm_pkg::REG_HEIGHT_SCALE:  scale_in = csr_write_data;
            htnm_pkg::REG_PIXEL_SPACING: spacing_in = csr_write_data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         htnm_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               cur_in   = req_chan.height_sample;
               wlast_in = COL_W'(wfull - 32'd1);
               hlast_in = ROW_W'(hfull - 32'd1);
               col_in   = (col_cnt_ff < COL_W'(wfull - 32'd1)) ? col_cnt_ff
                                                               : COL_W'(wfull - 32'd1);
               row_in   = (row_cnt_ff < ROW_W'(hfull - 32'd1)) ? row_cnt_ff
                                                               : ROW_W'(hfull - 32'd1);
            end
         end
         htnm_pkg::ST_RD_RIGHT: old_in = mem_q;
         htnm_pkg::ST_SETUP: begin
            job_in  = build_job;
            njob_in = build_n;
            jidx_in = 2'd0;
         end
         htnm_pkg::ST_MUL_H: begin
            hneg_in = (job_cur.hnb > job_cur.centre);
            dh_in   = SW'(mul_prod);
         end
         htnm_pkg::ST_MUL_V: begin
            vneg_in = (job_cur.vnb > job_cur.centre);
            dv_in   = SW'(mul_prod);
         end
         htnm_pkg::ST_DIV_H: dh_in = dh_ff + SW'(mul_prod >> htnm_pkg::SLOPE_RECIP_SHIFT);
         htnm_pkg::ST_DIV_V: dv_in = dv_ff + SW'(mul_prod >> htnm_pkg::SLOPE_RECIP_SHIFT);
         htnm_pkg::ST_SQ_H:  acc_in = mul_prod;
         htnm_pkg::ST_SQ_V:  acc_in = acc_ff + mul_prod;
         htnm_pkg::ST_SQ_S: begin
            sq_v_in   = acc_ff + mul_prod;
            sq_res_in = '0;
            sq_bit_in = QW'(1) << (2 * (htnm_pkg::SQ_STEPS - 1));
            sq_cnt_in = '0;
         end
         // One digit of the integer square root per cycle
         htnm_pkg::ST_SQRT: begin
            if (sq_v_ff >= sq_sum) begin
               sq_v_in   = sq_v_ff - sq_sum;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            sq_cnt_in = sq_cnt_ff + 1'b1;
         end
         htnm_pkg::ST_DIV_R: if (div_rsp.done) red_in = chan_map(hneg_ff, div_rsp.quotient[16:0]);
         htnm_pkg::ST_DIV_G: if (div_rsp.done) green_in = chan_map(vneg_ff, div_rsp.quotient[16:0]);
         htnm_pkg::ST_DIV_B: if (div_rsp.done) blue_in = chan_map(1'b0, div_rsp.quotient[16:0]);
         htnm_pkg::ST_EMIT: begin
            if (slot_free) begin
               out_col_in  = job_cur.col;
               out_row_in  = job_cur.row;
               out_r_in    = red_ff;
               out_g_in    = green_ff;
               out_b_in    = blue_ff;
               out_last_in = last_job;
               if (!last_job) jidx_in = jidx_ff + 2'd1;
            end
         end
         // Advance neighbors and raster position
         htnm_pkg::ST_WRAP: begin
            upl_in  = old_ff;
            left_in = cur_ff;
            if (col_ff != wlast_ff) begin
               col_cnt_in = col_ff + 1'b1;
               row_cnt_in = row_ff;
            end else begin
               col_cnt_in = '0;
               row_cnt_in = (row_ff != hlast_ff) ? (row_ff + 1'b1) : '0;
            end
         end
         default: begin
         end
      endcase

      // Hold the result until the sink takes it
      rsp_valid_in = emit_load | (rsp_valid_ff & ~rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      old_ff      <= old_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      wlast_ff    <= wlast_in;
      hlast_ff    <= hlast_in;
      job_ff      <= job_in;
      njob_ff     <= njob_in;
      jidx_ff     <= jidx_in;
      hneg_ff     <= hneg_in;
      vneg_ff     <= vneg_in;
      dh_ff       <= dh_in;
      dv_ff       <= dv_in;
      acc_ff      <= acc_in;
      sq_v_ff     <= sq_v_in;
      sq_res_ff   <= sq_res_in;
      sq_bit_ff   <= sq_bit_in;
      sq_cnt_ff   <= sq_cnt_in;
      red_ff      <= red_in;
      green_ff    <= green_in;
      blue_ff     <= blue_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_r_ff    <= out_r_in;
      out_g_ff    <= out_g_in;
      out_b_ff    <= out_b_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         state_ff      <= htnm_pkg::ST_IDLE;
         width_cfg_ff  <= htnm_pkg::WIDTH_RESET;
         height_cfg_ff <= htnm_pkg::HEIGHT_RESET;
         scale_ff      <= htnm_pkg::SCALE_RESET;
         spacing_ff    <= htnm_pkg::SPACING_RESET;
         col_cnt_ff    <= '0;
         row_cnt_ff    <= '0;
         left_ff       <= '0;
         upl_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
         scale_ff      <= scale_in;
         spacing_ff    <= spacing_in;
         col_cnt_ff    <= col_cnt_in;
         row_cnt_ff    <= row_cnt_in;
         left_ff       <= left_in;
         upl_ff        <= upl_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pixel_column = out_col_ff;
   assign rsp_chan.pixel_row    = out_row_ff;
   assign rsp_chan.normal_red   = out_r_ff;
   assign rsp_chan.normal_green = out_g_ff;
   assign rsp_chan.normal_blue  = out_b_ff;
   assign rsp_chan.last_of_run  = out_last_ff;

endmodule

/* hdl/htnm_checker.sv */
`timescale 1ns / 1ps

module htnm_checker #(
   parameter int COL_W = 10,
   parameter int ROW_W = 12
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [COL_W-1:0] rsp_pixel_column,
   input logic [ROW_W-1:0] rsp_pixel_row,
   input logic             rsp_last_of_run
);

   // Reset empties the result register and leaves the block ready
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("result pending or block busy after reset");

   // An accepted transaction occupies the block on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block ready right after accepting a transaction");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_column)
                                  && $stable(rsp_pixel_row) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

endmodule

bind height_to_normal_map htnm_checker #(.COL_W(COL_W), .ROW_W(ROW_W)) u_htnm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_pixel_column (rsp_chan.pixel_column),
   .rsp_pixel_row    (rsp_chan.pixel_row),
   .rsp_last_of_run  (rsp_chan.last_of_run)
);
